### src/frc_pkg.sv
package frc_pkg;

  // sample and coefficient widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned COEF_IDX_W = 9;
  localparam int unsigned TAPS_DEF   = 80;

  // register indexes
  localparam logic [1:0] REG_IR_SELECT = 2'd0;
  localparam logic [1:0] REG_SEND_GAIN = 2'd1;
  localparam logic [1:0] REG_WET_MIX   = 2'd2;

  // register reset values
  localparam logic [GAIN_W-1:0] SEND_GAIN_RST = 16'd7864;
  localparam logic [GAIN_W-1:0] WET_MIX_RST   = 16'd14418;

  localparam int unsigned VEH_LEN = 26;
  localparam int unsigned URB_LEN = 80;

  // vehicle impulse response, q1.17
  localparam logic [COEF_W-1:0] VEH_COEF [VEH_LEN] = '{
    18'd131072, 18'd39322, 18'd15729, 18'd7864, 18'd3932, 18'd1966, 18'd918,
    18'd459, 18'd236, 18'd118, 18'd66, 18'd33, 18'd16, 18'd8, 18'd4, 18'd2,
    18'd33, 18'd52, 18'd39, 18'd24, 18'd13, 18'd8, 18'd4, 18'd3, 18'd1, 18'd0
  };

  // urban impulse response, q1.17
  localparam logic [COEF_W-1:0] URB_COEF [URB_LEN] = '{
    18'd111411, 18'd55050, 18'd34079, 18'd19661, 18'd11796, 18'd7209,
    18'd4588, 18'd2884, 18'd1835, 18'd1180, 18'd786, 18'd524, 18'd341,
    18'd249, 18'd170, 18'd118, 18'd144, 18'd138, 18'd131, 18'd125, 18'd118,
    18'd111, 18'd105, 18'd98, 18'd92, 18'd85, 18'd79, 18'd72, 18'd66,
    18'd59, 18'd52, 18'd46, 18'd42, 18'd39, 18'd35, 18'd33, 18'd29, 18'd26,
    18'd24, 18'd21, 18'd18, 18'd16, 18'd13, 18'd12, 18'd10, 18'd9, 18'd8,
    18'd7, 18'd5, 18'd5, 18'd4, 18'd4, 18'd3, 18'd3, 18'd3, 18'd2, 18'd2,
    18'd2, 18'd2, 18'd2, 18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 18'd1,
    18'd1, 18'd1, 18'd1, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0,
    18'd0, 18'd0, 18'd0
  };

  // coefficient lookup, taps past the end of a table weigh zero
  function automatic logic [COEF_W-1:0] coef_at(input logic sel,
                                                input logic [COEF_IDX_W-1:0] k);
    logic [COEF_W-1:0] c;
    c = '0;
    if (!sel) begin
      if (k < COEF_IDX_W'(VEH_LEN)) c = VEH_COEF[k[4:0]];
    end else begin
      if (k < COEF_IDX_W'(URB_LEN)) c = URB_COEF[k[6:0]];
    end
    return c;
  endfunction

  // control from the sequencer to the history chain
  typedef struct packed {
    logic en;    // move every cell one place
    logic load;  // head takes a new word instead of the tail
  } chain_ctrl_t;

endpackage

### src/frc_cell.sv
module frc_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [frc_pkg::SAMPLE_W-1:0]      d_i,
  output logic [frc_pkg::SAMPLE_W-1:0]      q_o
);

  logic [frc_pkg::SAMPLE_W-1:0] data_q;

  // one history entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (en_i) begin
      data_q <= d_i;
    end
  end

  assign q_o = data_q;

endmodule

### src/frc_chain.sv
module frc_chain #(
  parameter int unsigned TAPS = frc_pkg::TAPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  frc_pkg::chain_ctrl_t              ctrl_i,
  input  logic [frc_pkg::SAMPLE_W-1:0]      head_i,
  output logic [frc_pkg::SAMPLE_W-1:0]      tail_o
);

  logic [frc_pkg::SAMPLE_W-1:0] cell_q [TAPS];
  logic [frc_pkg::SAMPLE_W-1:0] head_d;

  // head takes the new word on a shift, the tail word on a rotation
  assign head_d = ctrl_i.load ? head_i : cell_q[TAPS-1];

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    logic [frc_pkg::SAMPLE_W-1:0] d;
    if (k == 0) begin : g_head
      assign d = head_d;
    end else begin : g_body
      assign d = cell_q[k-1];
    end
    frc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (ctrl_i.en),
      .d_i    (d),
      .q_o    (cell_q[k])
    );
  end

  assign tail_o = cell_q[TAPS-1];

endmodule

### src/fir_convolution_reverb.sv
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------
// input     | in_valid_i / in_ready_o    | dry_sample_i
// output    | out_valid_o / out_ready_i  | mixed_sample_o, wet_sample_o
// config    | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// from acceptance to the next acceptance, the history rotates once through a
// chain of TAPS cells past a single multiply-accumulate, plus shift, drain,
// rounding and mix steps.
// reset clears the history and loads the register defaults; no clearing pass.
// a held result does not block the next input word; the sequencer waits in its
// last step only while an earlier result is still untaken.
module fir_convolution_reverb #(
  parameter int unsigned TAPS = frc_pkg::TAPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [frc_pkg::SAMPLE_W-1:0] dry_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [frc_pkg::SAMPLE_W-1:0] mixed_sample_o,
  output logic signed [frc_pkg::SAMPLE_W-1:0] wet_sample_o,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [frc_pkg::GAIN_W-1:0]        cfg_data_i
);

  localparam int unsigned SW     = frc_pkg::SAMPLE_W;
  localparam int unsigned IDX_W  = $clog2(TAPS);
  localparam int unsigned SEND_W = SW + frc_pkg::GAIN_W + 1;
  localparam int unsigned PROD_W = SW + frc_pkg::COEF_W + 1;
  localparam int unsigned ACC_W  = PROD_W + IDX_W;
  localparam int unsigned MIX_W  = SW + 18;
  localparam int unsigned SUM_W  = MIX_W + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_MAC, S_DRAIN, S_WET, S_MIX, S_SUM
  } state_e;

  state_e state_q;

  logic                            ir_sel_q;
  logic [frc_pkg::GAIN_W-1:0]      send_gain_q;
  logic [frc_pkg::GAIN_W-1:0]      wet_mix_q;

  logic signed [SW-1:0]            dry_q;
  logic signed [SEND_W-1:0]        send_prod_q;
  logic [IDX_W-1:0]                cnt_q;
  logic signed [PROD_W-1:0]        prod_q;
  logic                            prod_vld_q;
  logic signed [ACC_W-1:0]         acc_q;
  logic signed [SW-1:0]            wet_q;
  logic signed [MIX_W-1:0]         mdry_q;
  logic signed [MIX_W-1:0]         mwet_q;
  logic                            out_valid_q;
  logic signed [SW-1:0]            mixed_out_q;
  logic signed [SW-1:0]            wet_out_q;

  frc_pkg::chain_ctrl_t            chain_ctrl;
  logic [SW-1:0]                   send_word;
  logic [SW-1:0]                   tail;
  logic [IDX_W-1:0]                tap_idx;
  logic [frc_pkg::COEF_W-1:0]      coef;
  logic signed [PROD_W-1:0]        prod_d;
  logic signed [SEND_W-1:0]        send_rnd;
  logic signed [ACC_W-1:0]         acc_rnd;
  logic signed [ACC_W-1:0]         acc_sh;
  logic signed [SW-1:0]            wet_d;
  logic [16:0]                     dry_wt;
  logic signed [SUM_W-1:0]         mix_sum;
  logic signed [SUM_W-1:0]         mix_sh;
  logic signed [SW-1:0]            mixed_d;
  logic                            out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ir_sel_q    <= 1'b0;
      send_gain_q <= frc_pkg::SEND_GAIN_RST;
      wet_mix_q   <= frc_pkg::WET_MIX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        frc_pkg::REG_IR_SELECT: ir_sel_q    <= cfg_data_i[0];
        frc_pkg::REG_SEND_GAIN: send_gain_q <= cfg_data_i;
        frc_pkg::REG_WET_MIX:   wet_mix_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // send word, rounded; always fits in 16 bits
  assign send_rnd  = send_prod_q + SEND_W'(32768);
  assign send_word = send_rnd[SW+15:16];

  // history chain: shift in the send word, then rotate once for the sum
  always_comb begin
    chain_ctrl.en   = (state_q == S_SHIFT) || (state_q == S_MAC);
    chain_ctrl.load = (state_q == S_SHIFT);
  end

  frc_chain #(.TAPS(TAPS)) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (chain_ctrl),
    .head_i (send_word),
    .tail_o (tail)
  );

  // the tail holds the oldest entry first, so taps run downwards
  assign tap_idx = IDX_W'(TAPS - 1) - cnt_q;
  assign coef    = frc_pkg::coef_at(ir_sel_q, frc_pkg::COEF_IDX_W'(tap_idx));
  assign prod_d  = PROD_W'($signed(tail)) * PROD_W'($signed({1'b0, coef}));

  // wet rounding and saturation
  assign acc_rnd = acc_q + ACC_W'(65536);
  assign acc_sh  = acc_rnd >>> 17;
  always_comb begin
    if (acc_sh > ACC_W'(32767)) begin
      wet_d = 16'sh7fff;
    end else if (acc_sh < -ACC_W'(32768)) begin
      wet_d = -16'sh8000;
    end else begin
      wet_d = acc_sh[SW-1:0];
    end
  end

  // dry weight is one minus the wet fraction
  assign dry_wt = 17'h10000 - {1'b0, wet_mix_q};

  // mix rounding and saturation
  assign mix_sum = SUM_W'(mdry_q) + SUM_W'(mwet_q) + SUM_W'(32768);
  assign mix_sh  = mix_sum >>> 16;
  always_comb begin
    if (mix_sh > SUM_W'(32767)) begin
      mixed_d = 16'sh7fff;
    end else if (mix_sh < -SUM_W'(32768)) begin
      mixed_d = -16'sh8000;
    end else begin
      mixed_d = mix_sh[SW-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // sequencer with multiply-accumulate and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // result flag: set at the last step, cleared when taken
      if (state_q == S_SUM && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            dry_q       <= dry_sample_i;
            send_prod_q <= SEND_W'(dry_sample_i) * SEND_W'($signed({1'b0, send_gain_q}));
            state_q     <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_MAC;
        end
        S_MAC: begin
          prod_q     <= prod_d;
          prod_vld_q <= 1'b1;
          if (prod_vld_q) acc_q <= acc_q + ACC_W'(prod_q);
          if (cnt_q == IDX_W'(TAPS - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DRAIN: begin
          acc_q      <= acc_q + ACC_W'(prod_q);
          prod_vld_q <= 1'b0;
          state_q    <= S_WET;
        end
        S_WET: begin
          wet_q   <= wet_d;
          state_q <= S_MIX;
        end
        S_MIX: begin
          mdry_q  <= MIX_W'(dry_q) * MIX_W'($signed({1'b0, dry_wt}));
          mwet_q  <= MIX_W'(wet_q) * MIX_W'($signed({2'b0, wet_mix_q}));
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            mixed_out_q <= mixed_d;
            wet_out_q   <= wet_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = mixed_out_q;
  assign wet_sample_o   = wet_out_q;

endmodule

### tb/fir_convolution_reverb_test.sv
module fir_convolution_reverb_test;

  localparam int TAPS = frc_pkg::TAPS_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 200;
  // index past the last register, the block must ignore it
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef struct {
    logic signed [frc_pkg::SAMPLE_W-1:0] mixed;
    logic signed [frc_pkg::SAMPLE_W-1:0] wet;
  } reverb_result_t;

  // impulse responses, q1.17
  localparam int VEHICLE_IR [26] = '{
    131072, 39322, 15729, 7864, 3932, 1966, 918, 459, 236, 118,
    66, 33, 16, 8, 4, 2, 33, 52, 39, 24, 13, 8, 4, 3, 1, 0
  };
  localparam int URBAN_IR [80] = '{
    111411, 55050, 34079, 19661, 11796, 7209, 4588, 2884, 1835, 1180,
    786, 524, 341, 249, 170, 118, 144, 138, 131, 125, 118, 111, 105, 98,
    92, 85, 79, 72, 66, 59, 52, 46, 42, 39, 35, 33, 29, 26, 24, 21, 18, 16,
    13, 12, 10, 9, 8, 7, 5, 5, 4, 4, 3, 3, 3, 2, 2, 2, 2, 2,
    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [frc_pkg::SAMPLE_W-1:0] dry_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [frc_pkg::SAMPLE_W-1:0] mixed_sample;
  logic signed [frc_pkg::SAMPLE_W-1:0] wet_sample;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [frc_pkg::GAIN_W-1:0] cfg_data = '0;

  // predictor state: register copies and the send history line
  logic ir_sel_q = 1'b0;
  logic [frc_pkg::GAIN_W-1:0] gain_q = 16'd7864;
  logic [frc_pkg::GAIN_W-1:0] wmix_q = 16'd14418;
  logic signed [frc_pkg::SAMPLE_W-1:0] send_line [TAPS] = '{default: '0};

  logic [frc_pkg::SAMPLE_W-1:0] pending_words [$];
  reverb_result_t expected_results [$];
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  int quiet = 0;
  bit calm = 1'b0;

  fir_convolution_reverb u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .dry_sample_i   (dry_sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .mixed_sample_o (mixed_sample),
    .wet_sample_o   (wet_sample),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic signed [frc_pkg::SAMPLE_W-1:0] sat16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[frc_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic longint tap_weight(input logic sel, input int k);
    if (!sel) return (k < 26) ? longint'(VEHICLE_IR[k]) : 64'sd0;
    return (k < 80) ? longint'(URBAN_IR[k]) : 64'sd0;
  endfunction

  // scale, shift into the history, convolve and mix one dry word
  function automatic void reverb_predict(input logic signed [frc_pkg::SAMPLE_W-1:0] dry);
    longint send;
    longint acc;
    longint mix;
    reverb_result_t r;
    send = (longint'(dry) * longint'(gain_q) + 32768) >>> 16;
    for (int k = TAPS - 1; k > 0; k--) send_line[k] = send_line[k-1];
    send_line[0] = sat16(send);
    acc = 0;
    for (int k = 0; k < TAPS; k++) acc += longint'(send_line[k]) * tap_weight(ir_sel_q, k);
    r.wet = sat16((acc + 65536) >>> 17);
    mix = longint'(dry) * (65536 - longint'(wmix_q)) + longint'(r.wet) * longint'(wmix_q)
          + 32768;
    r.mixed = sat16(mix >>> 16);
    expected_results.push_back(r);
  endfunction

  function automatic logic [frc_pkg::GAIN_W-1:0] pick_level();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return frc_pkg::GAIN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [frc_pkg::SAMPLE_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return frc_pkg::SAMPLE_W'($urandom_range(0, 64) - 32);
      default: return frc_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // register write, the predictor copy follows at once since the block is idle
  task automatic reg_write(input logic [1:0] idx, input logic [frc_pkg::GAIN_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      frc_pkg::REG_IR_SELECT: ir_sel_q = data[0];
      frc_pkg::REG_SEND_GAIN: gain_q = data;
      frc_pkg::REG_WET_MIX:   wmix_q = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // sender holds off until every expected word has come back
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) reverb_predict(dry_sample);
      if (in_valid && !in_ready) begin
        // hold the word until taken
      end else if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_valid <= 1'b1;
        dry_sample <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor and stall generator
  always @(posedge clk_i) begin
    reverb_result_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected word: expected none actual mixed %0d wet %0d",
                   $time, mixed_sample, wet_sample);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (mixed_sample !== want.mixed) begin
            $display("%0t mixed_sample mismatch: expected %0d actual %0d",
                     $time, want.mixed, mixed_sample);
            errors++;
          end
          if (wet_sample !== want.wet) begin
            $display("%0t wet_sample mismatch: expected %0d actual %0d",
                     $time, want.wet, wet_sample);
            errors++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moved
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog expired with %0d words outstanding", $time,
               expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    logic [frc_pkg::SAMPLE_W-1:0] w;
    int n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register defaults: extremes and bit patterns
    pending_words = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
    wait_idle();

    // urban response, full gain, fully wet: drive the wet sum into saturation
    reg_write(frc_pkg::REG_IR_SELECT, 16'h0001);
    reg_write(frc_pkg::REG_SEND_GAIN, 16'hFFFF);
    reg_write(frc_pkg::REG_WET_MIX, 16'hFFFF);
    cfg_we <= 1'b0;
    repeat (6) pending_words.push_back(16'h7FFF);
    repeat (6) pending_words.push_back(16'h8000);
    wait_idle();

    // upper bits of the select are dropped, stray index is ignored, fully dry
    reg_write(frc_pkg::REG_IR_SELECT, 16'hFFFE);
    reg_write(frc_pkg::REG_WET_MIX, 16'h0000);
    reg_write(REG_NONE, 16'h1234);
    cfg_we <= 1'b0;
    repeat (4) pending_words.push_back(16'h7FFF);
    wait_idle();

    // random phases, each with its own register setting
    for (int p = 0; p < 7; p++) begin
      reg_write(frc_pkg::REG_IR_SELECT, frc_pkg::GAIN_W'($urandom_range(0, 65535)));
      reg_write(frc_pkg::REG_SEND_GAIN, (p == 0) ? 16'h0000 : pick_level());
      reg_write(frc_pkg::REG_WET_MIX, pick_level());
      if ($urandom_range(0, 1) == 0)
        reg_write(REG_NONE, frc_pkg::GAIN_W'($urandom_range(0, 65535)));
      cfg_we <= 1'b0;
      if (p == 6) calm = 1'b1;
      n = 0;
      while (n < 95) begin
        if ($urandom_range(0, 15) == 0) begin
          // a held level puts a run of equal words into the history
          w = pick_word();
          repeat (10) pending_words.push_back(w);
          n += 10;
        end else begin
          pending_words.push_back(pick_word());
          n++;
        end
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
